[src/g3mc_pkg.sv]
// Shared types, constants and helpers of the 3x3 mine counter.
`default_nettype none

package g3mc_pkg;

   // register indexes on the configuration port
   localparam logic [1:0] REG_MARK_CHAR   = 2'd0;
   localparam logic [1:0] REG_ROW_COUNT   = 2'd1;
   localparam logic [1:0] REG_COL_COUNT   = 2'd2;

   localparam logic [7:0]  MARK_CHAR_RESET   = 8'd33;  // '!'
   localparam logic [12:0] ROW_COUNT_RESET   = 13'd1;
   localparam logic [5:0]  COL_COUNT_RESET   = 6'd1;
   localparam logic [12:0] MAX_ROWS          = 13'd4096;
   localparam logic [3:0]  MAX_COUNT         = 4'd9;

   typedef struct packed {
      logic [7:0]  mark_char;
      logic [12:0] row_count;
      logic [5:0]  col_count;
   } g3mc_cfg_type;

   // broadcast from the sequencer to every column cell
   typedef struct packed {
      logic       write;     // a word is being stored this cycle
      logic       clear;     // grid start: wipe every column
      logic       mine;      // mine bit of the incoming word
      logic [2:0] wr_slot;   // one-hot line slot of the incoming row
      logic [2:0] rd_mask;   // line slots that count for the target row
   } g3mc_cell_ctl_type;

   function automatic logic [1:0] slot_next(input logic [1:0] s);
      logic [1:0] n;
      n = (s == 2'd2) ? 2'd0 : s + 2'd1;
      return n;
   endfunction

   function automatic logic [1:0] slot_prev(input logic [1:0] s);
      logic [1:0] p;
      p = (s == 2'd0) ? 2'd2 : s - 2'd1;
      return p;
   endfunction

   function automatic logic [2:0] slot_bit(input logic [1:0] s);
      logic [2:0] b;
      b = 3'b001 << s;
      return b;
   endfunction

endpackage

`default_nettype wire

[src/g3mc_csr.sv]
// Configuration registers behind the APB-style port.
`default_nettype none

module g3mc_csr
   import g3mc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [3:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output g3mc_cfg_type      cfg
);

   g3mc_cfg_type cfg_ff, cfg_in;
   logic [1:0]   reg_index;
   logic         wr_en;

   assign reg_index = paddr[3:2];
   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_MARK_CHAR:   cfg_in.mark_char   = pwdata[7:0];
            REG_ROW_COUNT:   cfg_in.row_count   = pwdata[12:0];
            REG_COL_COUNT:   cfg_in.col_count   = pwdata[5:0];
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_MARK_CHAR:   prdata = {24'd0, cfg_ff.mark_char};
         REG_ROW_COUNT:   prdata = {19'd0, cfg_ff.row_count};
         REG_COL_COUNT:   prdata = {26'd0, cfg_ff.col_count};
         default:         prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mark_char   <= MARK_CHAR_RESET;
         cfg_ff.row_count   <= ROW_COUNT_RESET;
         cfg_ff.col_count   <= COL_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[src/g3mc_cell.sv]
// One column cell: three line slots of mine bits and its 3x3 count.
`default_nettype none

module g3mc_cell
   import g3mc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire g3mc_cell_ctl_type ctl,
   input  wire logic              sel,       // this column takes the word
   input  wire logic              in_grid,   // column lies inside the grid
   input  wire logic [1:0]        left_sum,
   input  wire logic [1:0]        right_sum,
   output logic [1:0]             own_sum,
   output logic [3:0]             count
);

   logic [2:0] slots_ff, slots_in;
   logic [2:0] hits;
   logic [2:0] put;

   assign put = ctl.mine ? ctl.wr_slot : 3'b000;

   always_comb begin
      slots_in = slots_ff;
      if (ctl.write) begin
         if (ctl.clear) begin
            slots_in = sel ? put : 3'b000;
         end else if (sel) begin
            slots_in = (slots_ff & ~ctl.wr_slot) | put;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= 3'b000;
      end else begin
         slots_ff <= slots_in;
      end
   end

   // vertical sum for the target row; zero outside the grid
   assign hits    = in_grid ? (slots_ff & ctl.rd_mask) : 3'b000;
   assign own_sum = 2'({1'b0, hits[0]} + {1'b0, hits[1]} + {1'b0, hits[2]});
   assign count   = 4'(left_sum) + 4'(own_sum) + 4'(right_sum);

endmodule

`default_nettype wire

[src/grid_3x3_mine_count.sv]
// Top level of the streamed 3x3 mine counter.
// An accepted item waits in the capture registers (cap_*, pend_ff); its results go to rsp
// through a single output register, one a cycle unless rsp_stall holds them. An item yields
// 0 to 4 results, and req_stall holds off new items until its results are all loaded.
// Typical rows give one result per item.
// Reset (synchronous): registers to their reset values, line store zero, position (0, 0).
`default_nettype none

module grid_3x3_mine_count
   import g3mc_pkg::*;
#(
   parameter int MAX_COLS = 32
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // input words
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_cell_char,
   // result words
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [11:0]                 rsp_row_index,
   output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] rsp_col_index,
   output logic [3:0]                  rsp_neighbor_count,
   output logic                        rsp_last_of_run,
   output logic                        rsp_end_of_grid,
   // configuration
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [3:0]             paddr,
   input  wire logic [31:0]            pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CW1   = COL_W + 1;   // wide enough to hold the column count itself

   // pending result codes, emitted lowest bit first
   localparam int PEND_ABOVE_LEFT = 0;  // (r-1, c-1)
   localparam int PEND_ABOVE_LAST = 1;  // (r-1, C-1)
   localparam int PEND_SAME_LEFT  = 2;  // (r, c-1) in the last row
   localparam int PEND_SAME_LAST  = 3;  // (r, C-1) on the final word

   // ---------------------------------------------------------------- config
   g3mc_cfg_type cfg;

   g3mc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // clamp sizes into their legal ranges
   logic [12:0]    rows;
   logic [CW1-1:0] cols;
   logic [6:0]     col_cfg7;

   assign col_cfg7 = {1'b0, cfg.col_count};

   always_comb begin
      if (cfg.row_count == 13'd0) begin
         rows = 13'd1;
      end else if (cfg.row_count > MAX_ROWS) begin
         rows = MAX_ROWS;
      end else begin
         rows = cfg.row_count;
      end
      if (col_cfg7 == 7'd0) begin
         cols = CW1'(1);
      end else if (col_cfg7 > 7'(MAX_COLS)) begin
         cols = CW1'(MAX_COLS);
      end else begin
         cols = CW1'(col_cfg7);
      end
   end

   // ---------------------------------------------------------------- position
   logic [11:0]      in_row_ff, in_row_in;
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [1:0]       in_slot_ff, in_slot_in;   // in_row mod 3

   logic [3:0]       pend_ff, pend_in;
   logic [3:0]       pick;
   logic [11:0]      cap_row_ff, cap_row_in;
   logic [COL_W-1:0] cap_col_ff, cap_col_in;
   logic [1:0]       cap_slot_ff, cap_slot_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic             out_of_grid;
   logic [11:0]      r;
   logic [COL_W-1:0] c;
   logic [1:0]       s;
   logic             mine;
   logic             r_first, c_first, r_last, c_last;
   logic [CW1-1:0]   c_plus1;

   assign req_stall = (pend_ff != 4'd0);
   assign accept    = req_valid && !req_stall;

   // a word stored outside the sizes now in force starts a new grid
   assign out_of_grid = ({1'b0, in_row_ff} >= rows) || ({1'b0, in_col_ff} >= cols);
   assign r = out_of_grid ? 12'd0 : in_row_ff;
   assign c = out_of_grid ? '0 : in_col_ff;
   assign s = out_of_grid ? 2'd0 : in_slot_ff;

   assign mine    = (req_cell_char == cfg.mark_char);
   assign r_first = (r == 12'd0);
   assign c_first = (c == '0);
   assign r_last  = ({1'b0, r} == rows - 13'd1);
   assign c_last  = ({1'b0, c} == cols - CW1'(1));
   assign c_plus1 = {1'b0, c} + CW1'(1);

   always_comb begin
      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      in_slot_in  = in_slot_ff;
      cap_row_in  = cap_row_ff;
      cap_col_in  = cap_col_ff;
      cap_slot_in = cap_slot_ff;
      pend_in     = pend_ff;
      if (accept) begin
         cap_row_in  = r;
         cap_col_in  = c;
         cap_slot_in = s;
         pend_in[PEND_ABOVE_LEFT] = !r_first && !c_first;
         pend_in[PEND_ABOVE_LAST] = !r_first && c_last;
         pend_in[PEND_SAME_LEFT]  = r_last && !c_first;
         pend_in[PEND_SAME_LAST]  = r_last && c_last;
         // advance the raster position
         if (c_plus1 < cols) begin
            in_row_in  = r;
            in_col_in  = COL_W'(c_plus1);
            in_slot_in = s;
         end else if (!r_last) begin
            in_row_in  = r + 12'd1;
            in_col_in  = '0;
            in_slot_in = slot_next(s);
         end else begin
            in_row_in  = 12'd0;
            in_col_in  = '0;
            in_slot_in = 2'd0;
         end
      end else if (pend_ff != 4'd0 && (!rsp_valid_ff || !rsp_stall)) begin
         pend_in = pend_ff & ~pick;
      end
   end

   // ---------------------------------------------------------------- result pick
   logic             tgt_above;
   logic [11:0]      tgt_row;
   logic [COL_W-1:0] tgt_col;
   logic [2:0]       rd_mask;
   logic [1:0]       ps;

   // lowest pending result goes first
   assign pick = pend_ff & (~pend_ff + 4'd1);
   assign tgt_above = pick[PEND_ABOVE_LEFT] || pick[PEND_ABOVE_LAST];
   assign ps = slot_prev(cap_slot_ff);

   always_comb begin
      tgt_row = tgt_above ? cap_row_ff - 12'd1 : cap_row_ff;
      if (pick[PEND_ABOVE_LEFT] || pick[PEND_SAME_LEFT]) begin
         tgt_col = cap_col_ff - COL_W'(1);
      end else begin
         tgt_col = COL_W'(cols - CW1'(1));
      end
      // slots of the rows around the target that lie inside the grid
      if (tgt_above) begin
         rd_mask = slot_bit(ps) | slot_bit(cap_slot_ff);
         if (cap_row_ff >= 12'd2) begin
            rd_mask = rd_mask | slot_bit(slot_prev(ps));
         end
      end else begin
         rd_mask = slot_bit(cap_slot_ff);
         if (cap_row_ff != 12'd0) begin
            rd_mask = rd_mask | slot_bit(ps);
         end
         if ({1'b0, cap_row_ff} + 13'd1 < rows) begin
            rd_mask = rd_mask | slot_bit(slot_next(cap_slot_ff));
         end
      end
   end

   // ---------------------------------------------------------------- cell chain
   g3mc_cell_ctl_type ctl;
   logic [1:0]        sums   [MAX_COLS];
   logic [3:0]        counts [MAX_COLS];

   assign ctl.write   = accept;
   assign ctl.clear   = r_first && c_first;
   assign ctl.mine    = mine;
   assign ctl.wr_slot = slot_bit(s);
   assign ctl.rd_mask = rd_mask;

   for (genvar k = 0; k < MAX_COLS; k++) begin : g_col
      logic [1:0] left_sum, right_sum;

      if (k == 0) begin : g_lft
         assign left_sum = 2'd0;
      end else begin : g_lft
         assign left_sum = sums[k-1];
      end
      if (k == MAX_COLS - 1) begin : g_rgt
         assign right_sum = 2'd0;
      end else begin : g_rgt
         assign right_sum = sums[k+1];
      end

      g3mc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .sel       (c == COL_W'(k)),
         .in_grid   (CW1'(k) < cols),
         .left_sum  (left_sum),
         .right_sum (right_sum),
         .own_sum   (sums[k]),
         .count     (counts[k])
      );
   end

   // ---------------------------------------------------------------- output register
   logic [11:0]      rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0] rsp_col_ff, rsp_col_in;
   logic [3:0]       rsp_cnt_ff, rsp_cnt_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_end_ff, rsp_end_in;
   logic             load;

   assign load = (pend_ff != 4'd0) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_end_in   = rsp_end_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = tgt_row;
         rsp_col_in   = tgt_col;
         rsp_cnt_in   = counts[tgt_col];
         rsp_last_in  = ((pend_ff & ~pick) == 4'd0);
         rsp_end_in   = ({1'b0, tgt_row} == rows - 13'd1)
                        && ({1'b0, tgt_col} == cols - CW1'(1));
      end else if (!rsp_stall) begin
         // drop the word once taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff    <= 12'd0;
         in_col_ff    <= '0;
         in_slot_ff   <= 2'd0;
         pend_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         in_slot_ff   <= in_slot_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: hold while stalled, no reset
   always_ff @(posedge clock) begin
      cap_row_ff  <= cap_row_in;
      cap_col_ff  <= cap_col_in;
      cap_slot_ff <= cap_slot_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_row_index      = rsp_row_ff;
   assign rsp_col_index      = rsp_col_ff;
   assign rsp_neighbor_count = rsp_cnt_ff;
   assign rsp_last_of_run    = rsp_last_ff;
   assign rsp_end_of_grid    = rsp_end_ff;

endmodule

`default_nettype wire

[src/g3mc_checker.sv]
// Port-level checks on the 3x3 mine counter, bound to the top level.
`default_nettype none

module g3mc_checker
   import g3mc_pkg::*;
#(
   parameter int MAX_COLS = 32
)
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire logic [11:0]          rsp_row_index,
   input wire logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] rsp_col_index,
   input wire logic [3:0]           rsp_neighbor_count,
   input wire logic                 rsp_last_of_run,
   input wire logic                 rsp_end_of_grid
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_row_index)
         && $stable(rsp_col_index) && $stable(rsp_neighbor_count))
      else $error("result word changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_neighbor_count <= MAX_COUNT)
      else $error("neighbour count above nine");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_grid |-> rsp_last_of_run)
      else $error("end of grid not on the last word of its run");

   // the words of one run leave back to back
   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=> rsp_valid)
      else $error("gap inside a run of results");

   // no new input word while a run is still open
   a_no_accept_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> !(req_valid && !req_stall))
      else $error("input taken while a run is open");

endmodule

bind grid_3x3_mine_count g3mc_checker #(.MAX_COLS(MAX_COLS)) u_g3mc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_row_index      (rsp_row_index),
   .rsp_col_index      (rsp_col_index),
   .rsp_neighbor_count (rsp_neighbor_count),
   .rsp_last_of_run    (rsp_last_of_run),
   .rsp_end_of_grid    (rsp_end_of_grid)
);

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for the streamed 3x3 mine counter: directed plan, then random grids.
module tb_top
   import g3mc_pkg::*;
();

   localparam int GRID_COLS     = 32;
   localparam int GRID_ROWS     = 4096;
   localparam int RANDOM_CELLS  = 90;
   // a word goes through capture registers and an output register; the settle wait covers one with no count
   localparam int SETTLE_CYCLES = 4;
   localparam int PLAN_LEN      = 33;

   // one count word as it leaves the block
   typedef struct packed {
      logic [11:0] row_index;
      logic [4:0]  col_index;
      logic [3:0]  neighbors;
      logic        last_of_run;
      logic        end_of_grid;
   } mine_count_type;

   typedef enum logic [0:0] {DO_CELL, DO_WRITE} plan_step_type;

   // one row of the directed plan: a register write or a cell word, with the count
   // typed in where it is obvious; rows without a typed count go through the predictor
   typedef struct packed {
      plan_step_type  step;
      logic [1:0]     reg_index;
      logic [12:0]    value;
      logic           typed;
      mine_count_type want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_cell_char = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_row_index;
   logic [4:0]  rsp_col_index;
   logic [3:0]  rsp_neighbor_count;
   logic        rsp_last_of_run;
   logic        rsp_end_of_grid;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = 4'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   // predictor state: registers in force, mine bits per column, position of the next cell
   g3mc_cfg_type   cfg;
   logic [2:0]     line_store [GRID_COLS];
   int             at_row;
   int             at_col;
   mine_count_type step_counts[$];
   mine_count_type pending_counts[$];

   int error_count = 0;
   int long_hold = 0;
   bit sender_gaps = 1'b0;
   bit receiver_stalls = 1'b0;

   plan_row_type plan [PLAN_LEN] = '{
      // reset state: 1x1 grid, marker '!'
      '{DO_CELL,  '0,              13'd33,   1'b1, '{12'd0, 5'd0, 4'd1, 1'b1, 1'b1}},
      '{DO_CELL,  '0,              13'd46,   1'b1, '{12'd0, 5'd0, 4'd0, 1'b1, 1'b1}},
      '{DO_CELL,  '0,              13'd255,  1'b1, '{12'd0, 5'd0, 4'd0, 1'b1, 1'b1}},
      // marker at both extremes
      '{DO_WRITE, REG_MARK_CHAR,   13'd0,    1'b0, '0},
      '{DO_CELL,  '0,              13'd0,    1'b1, '{12'd0, 5'd0, 4'd1, 1'b1, 1'b1}},
      '{DO_WRITE, REG_MARK_CHAR,   13'd255,  1'b0, '0},
      '{DO_CELL,  '0,              13'd255,  1'b1, '{12'd0, 5'd0, 4'd1, 1'b1, 1'b1}},
      // zero sizes clamp up to one
      '{DO_WRITE, REG_COL_COUNT,   13'd0,    1'b0, '0},
      '{DO_WRITE, REG_ROW_COUNT,   13'd0,    1'b0, '0},
      '{DO_CELL,  '0,              13'd254,  1'b1, '{12'd0, 5'd0, 4'd0, 1'b1, 1'b1}},
      // 3x3 of mines: the centre sees all nine
      '{DO_WRITE, REG_MARK_CHAR,   13'd42,   1'b0, '0},
      '{DO_WRITE, REG_ROW_COUNT,   13'd3,    1'b0, '0},
      '{DO_WRITE, REG_COL_COUNT,   13'd3,    1'b0, '0},
      '{DO_CELL,  '0,              13'd42,   1'b0, '0},
      '{DO_CELL,  '0,              13'd42,   1'b0, '0},
      '{DO_CELL,  '0,              13'd42,   1'b0, '0},
      '{DO_CELL,  '0,              13'd42,   1'b0, '0},
      '{DO_CELL,  '0,              13'd42,   1'b0, '0},
      '{DO_CELL,  '0,              13'd42,   1'b0, '0},
      '{DO_CELL,  '0,              13'd42,   1'b0, '0},
      '{DO_CELL,  '0,              13'd42,   1'b0, '0},
      '{DO_CELL,  '0,              13'd42,   1'b0, '0},
      // shrink the grid under a half-fed row: the position falls outside, so restart
      '{DO_WRITE, REG_ROW_COUNT,   13'd2,    1'b0, '0},
      '{DO_WRITE, REG_COL_COUNT,   13'd2,    1'b0, '0},
      '{DO_CELL,  '0,              13'd42,   1'b0, '0},
      '{DO_WRITE, REG_COL_COUNT,   13'd1,    1'b0, '0},
      '{DO_CELL,  '0,              13'd42,   1'b0, '0},
      '{DO_CELL,  '0,              13'd7,    1'b0, '0},
      // oversized values clamp to the largest grid
      '{DO_WRITE, REG_ROW_COUNT,   13'd8191, 1'b0, '0},
      '{DO_WRITE, REG_COL_COUNT,   13'd63,   1'b0, '0},
      '{DO_CELL,  '0,              13'd42,   1'b0, '0},
      '{DO_CELL,  '0,              13'd0,    1'b0, '0},
      '{DO_CELL,  '0,              13'd128,  1'b0, '0}
   };

   grid_3x3_mine_count #(
      .MAX_COLS(GRID_COLS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cell_char      (req_cell_char),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_row_index      (rsp_row_index),
      .rsp_col_index      (rsp_col_index),
      .rsp_neighbor_count (rsp_neighbor_count),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_end_of_grid    (rsp_end_of_grid),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle length, drawn from three ranges: mostly the shortest, now and then the longest.
   function automatic int pause_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return $urandom_range(1, 2);
      if (pick < 90) return $urandom_range(3, 6);
      return $urandom_range(12, 30);
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // Mines in the 3x3 window round (r, c); anything off the grid is empty.
   function automatic logic [3:0] mines_around(input int r, input int c,
                                               input int rows, input int cols);
      int total;
      int rr;
      int cc;
      total = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if (rr >= 0 && rr < rows && cc >= 0 && cc < cols)
               total += line_store[cc][rr % 3];
         end
      end
      return total[3:0];
   endfunction

   function automatic void add_count(input int r, input int c, input int rows, input int cols);
      mine_count_type m;
      m.row_index   = r[11:0];
      m.col_index   = c[4:0];
      m.neighbors   = mines_around(r, c, rows, cols);
      m.last_of_run = 1'b0;
      m.end_of_grid = (r == rows - 1 && c == cols - 1);
      step_counts.insert(step_counts.size(), m);
   endfunction

   // Take one cell word into the predictor and leave the counts it releases in step_counts.
   function automatic void advance_grid(input logic [7:0] ch);
      int rows;
      int cols;
      int r;
      int c;
      step_counts.delete();
      rows = int'(cfg.row_count);
      if (rows < 1) rows = 1;
      if (rows > GRID_ROWS) rows = GRID_ROWS;
      cols = int'(cfg.col_count);
      if (cols < 1) cols = 1;
      if (cols > GRID_COLS) cols = GRID_COLS;
      // position left outside a resized grid: start a fresh one
      if (at_row >= rows || at_col >= cols) begin
         at_row = 0;
         at_col = 0;
      end
      r = at_row;
      c = at_col;
      if (r == 0 && c == 0) begin
         foreach (line_store[i]) line_store[i] = 3'b000;
      end
      line_store[c][r % 3] = (ch == cfg.mark_char);
      // the row above trails by one column; the last row also flushes itself
      if (r >= 1 && c >= 1) add_count(r - 1, c - 1, rows, cols);
      if (r >= 1 && c == cols - 1) add_count(r - 1, cols - 1, rows, cols);
      if (r == rows - 1) begin
         if (c >= 1) add_count(r, c - 1, rows, cols);
         if (c == cols - 1) add_count(r, cols - 1, rows, cols);
      end
      if (step_counts.size() > 0)
         step_counts[step_counts.size() - 1].last_of_run = 1'b1;
      if (c + 1 < cols) begin
         at_col = c + 1;
      end else begin
         at_col = 0;
         at_row = (r + 1 < rows) ? r + 1 : 0;
      end
   endfunction

   // Drop valid and hold until every count owed has come back.
   task automatic drain_results();
      @(negedge clock) req_valid = 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
   endtask

   // Offer one cell word, hold it until taken, then book what it should release.
   task automatic send_cell(input logic [7:0] ch, input logic typed, input mine_count_type want);
      int gap;
      @(negedge clock);
      req_valid     = 1'b1;
      req_cell_char = ch;
      do @(posedge clock); while (req_stall);
      advance_grid(ch);
      if (typed) pending_counts.insert(pending_counts.size(), want);
      else foreach (step_counts[k]) pending_counts.insert(pending_counts.size(), step_counts[k]);
      gap = (sender_gaps && $urandom_range(0, 1) == 1) ? pause_len() : 0;
      if (gap > 0) begin
         @(negedge clock) req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Write a register once the block is idle, then read it back.
   task automatic write_register(input logic [1:0] idx, input logic [12:0] value);
      logic [31:0] want_read;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      want_read = '0;
      case (idx)
         REG_MARK_CHAR: begin
            cfg.mark_char = value[7:0];
            want_read     = {24'd0, value[7:0]};
         end
         REG_ROW_COUNT: begin
            cfg.row_count = value;
            want_read     = {19'd0, value};
         end
         REG_COL_COUNT: begin
            cfg.col_count = value[5:0];
            want_read     = {26'd0, value[5:0]};
         end
         default: begin
         end
      endcase
      // setup, then access
      @(negedge clock);
      psel    = 1'b1;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = {19'd0, value};
      @(negedge clock) penable = 1'b1;
      do @(posedge clock); while (!pready);
      // straight into the read-back setup
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock) penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want_read)
         report_mismatch($sformatf("register %0d read %0h want %0h", idx, prdata, want_read));
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // Result side: short random stalls, or one long hold-off counted here on request.
   initial begin : result_sink
      int run;
      forever begin
         @(negedge clock);
         if (long_hold > 0) begin
            run       = long_hold;
            long_hold = 0;
            rsp_stall = 1'b1;
            repeat (run) @(negedge clock);
            rsp_stall = 1'b0;
         end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
            run       = pause_len();
            rsp_stall = 1'b1;
            repeat (run) @(negedge clock);
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // Check each count word taken against the oldest one owed.
   always @(posedge clock) begin : count_check
      mine_count_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_counts.size() == 0) begin
            report_mismatch($sformatf("count word for (%0d,%0d) with nothing owed",
                                      rsp_row_index, rsp_col_index));
         end else begin
            want = pending_counts.pop_front();
            if (rsp_row_index !== want.row_index)
               report_mismatch($sformatf("row_index %0d want %0d",
                                         rsp_row_index, want.row_index));
            if (rsp_col_index !== want.col_index)
               report_mismatch($sformatf("col_index %0d want %0d",
                                         rsp_col_index, want.col_index));
            if (rsp_neighbor_count !== want.neighbors)
               report_mismatch($sformatf("neighbor_count %0d want %0d at (%0d,%0d)",
                                         rsp_neighbor_count, want.neighbors,
                                         want.row_index, want.col_index));
            if (rsp_last_of_run !== want.last_of_run)
               report_mismatch($sformatf("last_of_run %0b want %0b at (%0d,%0d)",
                                         rsp_last_of_run, want.last_of_run,
                                         want.row_index, want.col_index));
            if (rsp_end_of_grid !== want.end_of_grid)
               report_mismatch($sformatf("end_of_grid %0b want %0b at (%0d,%0d)",
                                         rsp_end_of_grid, want.end_of_grid,
                                         want.row_index, want.col_index));
         end
      end
   end

   initial begin : stimulus
      int         rows;
      int         cols;
      int         cells;
      int         fed;
      int         grid_no;
      logic [7:0] ch;

      cfg.mark_char = MARK_CHAR_RESET;
      cfg.row_count = ROW_COUNT_RESET;
      cfg.col_count = COL_COUNT_RESET;
      foreach (line_store[i]) line_store[i] = 3'b000;
      at_row = 0;
      at_col = 0;

      repeat (11) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // directed plan, no idling
      foreach (plan[i]) begin
         if (plan[i].step == DO_WRITE)
            write_register(plan[i].reg_index, plan[i].value);
         else
            send_cell(plan[i].value[7:0], plan[i].typed, plan[i].want);
      end

      // random grids; the first is full width, fed back to back into a long hold-off
      fed     = 0;
      grid_no = 0;
      while (fed < RANDOM_CELLS) begin
         if (grid_no == 0) begin
            rows = 1;
            cols = GRID_COLS;
         end else if ($urandom_range(0, 7) == 0) begin
            rows = $urandom_range(1, 2);
            cols = $urandom_range(9, GRID_COLS);
         end else begin
            rows = $urandom_range(1, 6);
            cols = $urandom_range(1, 8);
         end
         write_register(REG_MARK_CHAR, 13'($urandom_range(0, 255)));
         write_register(REG_ROW_COUNT, 13'(rows));
         write_register(REG_COL_COUNT, 13'(cols));
         sender_gaps     = (grid_no != 0) && ($urandom_range(0, 3) != 0);
         receiver_stalls = (grid_no != 0) && ($urandom_range(0, 3) != 0);
         cells = rows * cols;
         // now and then break a grid off part way; the next sizes may restart it
         if (grid_no > 0 && $urandom_range(0, 5) == 0) cells = $urandom_range(1, cells);
         if (cells > RANDOM_CELLS - fed) cells = RANDOM_CELLS - fed;
         if (grid_no == 0) long_hold = 80;
         for (int i = 0; i < cells; i++) begin
            if (i == cells / 2 && (grid_no == 1 || $urandom_range(0, 3) == 0))
               drain_results();
            ch = ($urandom_range(0, 99) < 45) ? cfg.mark_char : 8'($urandom_range(0, 255));
            send_cell(ch, 1'b0, '0);
         end
         fed += cells;
         grid_no++;
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_counts.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // Stop a run that hangs.
   initial begin : watchdog
      #5_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule

[filelist.f]
src/g3mc_pkg.sv
src/g3mc_csr.sv
src/g3mc_cell.sv
src/grid_3x3_mine_count.sv
src/g3mc_checker.sv
tb/sv/tb_top.sv
